### sv/avfs_pkg.sv
// avfs_pkg: shared types and constants for the airflow velocity block
// no dependencies; imported by the interfaces, the divider and the top level

package avfs_pkg;

  // field widths of the channels and the configuration port
  localparam int ADC_W      = 12;
  localparam int TEMP_W     = 15;
  localparam int VEL_OUT_W  = 16;
  localparam int CADC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int KCONST_W   = 10;

  // datapath widths
  localparam int K100_W  = 17;   // 100 * sensor constant
  localparam int SMAG_W  = 17;   // magnitude of temperature scale term
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = 35;
  localparam int DEN_W   = 17;   // divisor width of the shared divider

  // divide by 100 through reciprocal multiply, exact below 2^17
  localparam int                 RECIP_SHIFT = 24;
  localparam logic [MUL_B_W-1:0] RECIP_100   = 18'd167773;

  // temperature constants in hundredths of a degree
  localparam logic signed [TEMP_W-1:0] TEMP_LIMIT = 15'sd5000;
  localparam logic signed [18:0]       TEMP_REF   = 19'sd2500;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADC_ZERO     = 3'd0,
    REG_ADC_LOW      = 3'd1,
    REG_ADC_NOMINAL  = 3'd2,
    REG_VEL_ZERO     = 3'd3,
    REG_VEL_LOW      = 3'd4,
    REG_VEL_NOMINAL  = 3'd5,
    REG_SENSOR_CONST = 3'd6,
    REG_IMPERIAL     = 3'd7
  } avfs_reg_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COMP_PREP,
    ST_COMP_MUL,
    ST_COMP_DIV,
    ST_SEG_PREP,
    ST_SEG_MUL,
    ST_SEG_DIV,
    ST_ADJUST,
    ST_ROUND,
    ST_IMP_MUL,
    ST_IMP_SCALE,
    ST_FINISH
  } avfs_state_t;

endpackage

### sv/avfs_if.sv
// avfs_in_if / avfs_out_if: valid-ready channels for samples and results
// depends on avfs_pkg for the field widths

interface avfs_in_if import avfs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ADC_W-1:0]         adc_sample;
  logic signed [TEMP_W-1:0] temperature;

  modport source (output valid, output adc_sample, output temperature, input ready);
  modport sink   (input valid, input adc_sample, input temperature, output ready);
endinterface

interface avfs_out_if import avfs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VEL_OUT_W-1:0] velocity;
  logic [CADC_W-1:0]    compensated_adc;
  logic                 velocity_changed;

  modport source (output valid, output velocity, output compensated_adc,
                  output velocity_changed, input ready);
  modport sink   (input valid, input velocity, input compensated_adc,
                  input velocity_changed, output ready);
endinterface

### sv/airflow_velocity_from_sensor_adc.sv
// airflow_velocity_from_sensor_adc: temperature compensation and two-segment calibration
// a sample passes compensation, segment division, adjust and round, then the imperial scaling
// in imperial mode; compensation or the segment division is skipped when not needed;
// one transaction at a time, with both divisions on the shared radix-4 divider
// synchronous active-low reset clears config, stored velocity/compensated adc and the sequencer
// depends on avfs_pkg, avfs_if (channel interfaces) and avfs_div

module airflow_velocity_from_sensor_adc import avfs_pkg::*; #(
  parameter int ADC_BITS      = 12,
  parameter int FRACTION_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  avfs_in_if.sink               in_ch,
  avfs_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADC_EFF = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
  localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((32'd1 << ADC_EFF) - 32'd1);
  localparam int NUM_W = 32 + FRACTION_BITS + (FRACTION_BITS % 2);
  localparam int VEL_W = FRACTION_BITS + 34;
  localparam int PAD_W = VEL_W - 16 - FRACTION_BITS;

  localparam longint ImpThr = ((longint'(19685) << FRACTION_BITS) + 50) / 100;
  localparam longint ImpOff = ((longint'(98425) << FRACTION_BITS) + 500) / 1000;

  localparam logic signed [VEL_W-1:0] FX_ONE    = VEL_W'(longint'(1) << FRACTION_BITS);
  localparam logic signed [VEL_W-1:0] FX_HALF   = VEL_W'(longint'(1) << (FRACTION_BITS - 1));
  localparam logic signed [VEL_W-1:0] FX_FIFTY  = VEL_W'(longint'(50) << FRACTION_BITS);
  localparam logic signed [VEL_W-1:0] FX_SAT    = VEL_W'(longint'(1) << (FRACTION_BITS + 32));
  localparam logic signed [VEL_W-1:0] IMP_THR   = VEL_W'(ImpThr);
  localparam logic signed [VEL_W-1:0] IMP_OFF   = VEL_W'(ImpOff);
  localparam logic signed [VEL_W-1:0] OUT_MAX   = VEL_W'(longint'(65535));
  localparam logic signed [VEL_W-1:0] IMP_LIMIT = VEL_W'(longint'(65600));

  // configuration registers
  logic [ADC_W-1:0]     cfg_zero_r, cfg_low_r, cfg_nom_r;
  logic [VEL_OUT_W-1:0] cfg_vz_r, cfg_vl_r, cfg_vn_r;
  logic [KCONST_W-1:0]  cfg_k_r;
  logic                 cfg_imperial_r;

  avfs_state_t state_r, state_nxt;

  // working registers
  logic [ADC_W-1:0]         adc_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [K100_W-1:0]        k100_r;
  logic                     s_neg_r;
  logic [SMAG_W-1:0]        s_mag_r;
  logic [CADC_W-1:0]        c_r;
  logic [15:0]              xd_r;
  logic [VEL_OUT_W-1:0]     y0_r;
  logic [15:0]              dy_mag_r;
  logic                     dy_neg_r, dy_zero_r;
  logic [ADC_W-1:0]         dx_mag_r;
  logic                     dx_neg_r, dx_zero_r;
  logic signed [VEL_W-1:0]  vel_r;
  logic [16:0]              vq_r;
  logic [9:0]               q100_r;
  logic [VEL_OUT_W-1:0]     res_r;
  logic [VEL_OUT_W-1:0]     stored_vel_r;
  logic [CADC_W-1:0]        stored_comp_r;
  logic                     changed_r;
  logic                     out_valid_r;

  // combinational signals
  logic                    in_ready;
  logic                    slot_free;
  logic                    comp_on;
  logic [K100_W-1:0]       k100;
  logic signed [18:0]      s_full, s_abs;
  logic [NUM_W-1:0]        comp_q;
  logic [CADC_W-1:0]       comp_c;
  logic                    below_zero, seg_hi;
  logic [ADC_W-1:0]        x0, x1;
  logic [VEL_OUT_W-1:0]    y0, y1;
  logic signed [12:0]      dx_full, dx_abs;
  logic signed [16:0]      dy_full, dy_abs;
  logic [15:0]             xd;
  logic signed [VEL_W-1:0] y0_fx, vlow_fx, vnom_fx;
  logic signed [VEL_W-1:0] flat_vel, q_s, seg_vel;
  logic signed [VEL_W-1:0] diff, thr, off, adj_vel;
  logic                    near_low;
  logic                    above_nom, vel_pos, imp_sat;
  logic signed [VEL_W-1:0] bias, biased, sh;
  logic [VEL_OUT_W-1:0]    metric_res;
  logic [VEL_OUT_W-1:0]    imp_res;
  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [MUL_P_W-1:0]      mul_p;
  logic                    div_start, div_done;
  logic [NUM_W-1:0]        div_num, div_quot;
  logic [DEN_W-1:0]        div_den;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_zero_r     <= '0;
      cfg_low_r      <= '0;
      cfg_nom_r      <= '0;
      cfg_vz_r       <= '0;
      cfg_vl_r       <= '0;
      cfg_vn_r       <= '0;
      cfg_k_r        <= '0;
      cfg_imperial_r <= 1'b0;
    end else if (cfg_we) begin
      case (avfs_reg_t'(cfg_index))
        REG_ADC_ZERO:     cfg_zero_r     <= cfg_data[ADC_W-1:0];
        REG_ADC_LOW:      cfg_low_r      <= cfg_data[ADC_W-1:0];
        REG_ADC_NOMINAL:  cfg_nom_r      <= cfg_data[ADC_W-1:0];
        REG_VEL_ZERO:     cfg_vz_r       <= cfg_data[VEL_OUT_W-1:0];
        REG_VEL_LOW:      cfg_vl_r       <= cfg_data[VEL_OUT_W-1:0];
        REG_VEL_NOMINAL:  cfg_vn_r       <= cfg_data[VEL_OUT_W-1:0];
        REG_SENSOR_CONST: cfg_k_r        <= cfg_data[KCONST_W-1:0];
        REG_IMPERIAL:     cfg_imperial_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // shared multiplier
  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // shared divider
  avfs_div #(
    .NUM_W (NUM_W),
    .DIV_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // compensation terms
  always_comb begin
    comp_on = (cfg_k_r != '0) && (temp_r <= TEMP_LIMIT);
    k100    = K100_W'({cfg_k_r, 6'b0}) + K100_W'({cfg_k_r, 5'b0})
            + K100_W'({cfg_k_r, 2'b0});
    s_full  = 19'(temp_r) - TEMP_REF + $signed({2'b00, k100});
    s_abs   = s_full[18] ? -s_full : s_full;
    comp_q  = div_quot;
    if (s_neg_r) begin
      comp_c = (comp_q != '0) ? CADC_W'(adc_r) : '0;
    end else begin
      comp_c = (comp_q > NUM_W'(32'd65535)) ? 16'hFFFF : comp_q[15:0];
    end
  end

  // segment selection and differences
  always_comb begin
    below_zero = (c_r < CADC_W'(cfg_zero_r));
    seg_hi     = (c_r >= CADC_W'(cfg_low_r));
    x0         = seg_hi ? cfg_low_r : cfg_zero_r;
    x1         = seg_hi ? cfg_nom_r : cfg_low_r;
    y0         = seg_hi ? cfg_vl_r  : cfg_vz_r;
    y1         = seg_hi ? cfg_vn_r  : cfg_vl_r;
    dx_full    = $signed({1'b0, x1}) - $signed({1'b0, x0});
    dy_full    = $signed({1'b0, y1}) - $signed({1'b0, y0});
    dx_abs     = dx_full[12] ? -dx_full : dx_full;
    dy_abs     = dy_full[16] ? -dy_full : dy_full;
    xd         = c_r - CADC_W'(x0);
  end

  // fixed-point velocity terms
  always_comb begin
    y0_fx    = $signed({{PAD_W{1'b0}}, y0_r, {FRACTION_BITS{1'b0}}});
    vlow_fx  = $signed({{PAD_W{1'b0}}, cfg_vl_r, {FRACTION_BITS{1'b0}}});
    vnom_fx  = $signed({{PAD_W{1'b0}}, cfg_vn_r, {FRACTION_BITS{1'b0}}});
    flat_vel = (xd_r == '0) ? y0_fx : (dy_neg_r ? -FX_SAT : FX_SAT);
    q_s      = $signed(VEL_W'(div_quot));
    seg_vel  = ((dy_neg_r ^ dx_neg_r) ? -q_s : q_s) + y0_fx;
  end

  // offset near the low alarm point: half a unit in metric, the imperial offset in imperial mode
  always_comb begin
    diff     = vel_r - vlow_fx;
    thr      = cfg_imperial_r ? IMP_THR : FX_ONE;
    off      = cfg_imperial_r ? IMP_OFF : FX_HALF;
    near_low = (diff <= thr) && (diff >= -thr);
    adj_vel  = near_low ? (vel_r - off) : vel_r;
  end

  // rounding, truncation and saturation
  always_comb begin
    above_nom  = (vel_r > vnom_fx);
    vel_pos    = (vel_r > $signed(VEL_W'(0)));
    bias       = above_nom ? '0 : (cfg_imperial_r ? FX_FIFTY : FX_HALF);
    biased     = vel_r + bias;
    sh         = biased >>> FRACTION_BITS;
    metric_res = (sh > OUT_MAX) ? 16'hFFFF : sh[15:0];
    imp_sat    = (sh >= IMP_LIMIT);
    imp_res    = 16'({q100_r, 6'b0}) + 16'({q100_r, 5'b0}) + 16'({q100_r, 2'b0});
  end

  assign slot_free = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_ch.valid) state_nxt = ST_COMP_PREP;
      ST_COMP_PREP: state_nxt = comp_on ? ST_COMP_MUL : ST_SEG_PREP;
      ST_COMP_MUL:  state_nxt = ST_COMP_DIV;
      ST_COMP_DIV:  if (div_done) state_nxt = ST_SEG_PREP;
      ST_SEG_PREP:  state_nxt = below_zero ? ST_ADJUST : ST_SEG_MUL;
      ST_SEG_MUL:   state_nxt = dx_zero_r ? ST_ADJUST : ST_SEG_DIV;
      ST_SEG_DIV:   if (div_done) state_nxt = ST_ADJUST;
      ST_ADJUST:    state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (vel_pos && cfg_imperial_r && !imp_sat) state_nxt = ST_IMP_MUL;
        else state_nxt = ST_FINISH;
      end
      ST_IMP_MUL:   state_nxt = ST_IMP_SCALE;
      ST_IMP_SCALE: state_nxt = ST_FINISH;
      ST_FINISH:    if (slot_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake, multiplier and divider operands
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_COMP_MUL: begin
        mul_a     = MUL_A_W'(adc_r);
        mul_b     = MUL_B_W'(s_mag_r);
        div_start = 1'b1;
        div_num   = NUM_W'(mul_p);
        div_den   = k100_r;
      end
      ST_SEG_MUL: begin
        mul_a     = MUL_A_W'(xd_r);
        mul_b     = MUL_B_W'(dy_mag_r);
        div_start = !dx_zero_r;
        div_num   = dy_zero_r ? NUM_W'(xd_r) : (NUM_W'(mul_p[31:0]) << FRACTION_BITS);
        div_den   = DEN_W'(dx_mag_r);
      end
      ST_IMP_MUL: begin
        mul_a = vq_r;
        mul_b = RECIP_100;
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // working datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        adc_r  <= in_ch.adc_sample & ADC_MASK;
        temp_r <= in_ch.temperature;
      end
      ST_COMP_PREP: begin
        k100_r  <= k100;
        s_neg_r <= s_full[18];
        s_mag_r <= s_abs[SMAG_W-1:0];
        c_r     <= CADC_W'(adc_r);
      end
      ST_COMP_DIV: if (div_done) c_r <= comp_c;
      ST_SEG_PREP: begin
        xd_r      <= xd;
        y0_r      <= y0;
        dy_mag_r  <= dy_abs[15:0];
        dy_neg_r  <= dy_full[16];
        dy_zero_r <= (dy_full == '0);
        dx_mag_r  <= dx_abs[ADC_W-1:0];
        dx_neg_r  <= dx_full[12];
        dx_zero_r <= (dx_full == '0);
        vel_r     <= '0;
      end
      ST_SEG_MUL: if (dx_zero_r) vel_r <= flat_vel;
      ST_SEG_DIV: if (div_done) vel_r <= seg_vel;
      ST_ADJUST:  vel_r <= adj_vel;
      ST_ROUND: begin
        vq_r <= sh[16:0];
        if (!vel_pos) res_r <= '0;
        else if (!cfg_imperial_r) res_r <= metric_res;
        else if (imp_sat) res_r <= 16'hFFFF;
      end
      ST_IMP_MUL:   q100_r <= mul_p[RECIP_SHIFT+9:RECIP_SHIFT];
      ST_IMP_SCALE: res_r  <= imp_res;
      default: ;
    endcase
  end

  // stored state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_vel_r  <= '0;
      stored_comp_r <= '0;
      changed_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else if (state_r == ST_FINISH && slot_free) begin
      stored_vel_r  <= res_r;
      stored_comp_r <= c_r;
      changed_r     <= (res_r != stored_vel_r);
      out_valid_r   <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r   <= 1'b0;
    end
  end

  assign in_ch.ready             = in_ready;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.velocity         = stored_vel_r;
  assign out_ch.compensated_adc  = stored_comp_r;
  assign out_ch.velocity_changed = changed_r;

  // divider completes only while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_COMP_DIV || state_r == ST_SEG_DIV))
    else $error("divider done outside a wait state");

  // an accepted transaction starts the compensation step
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_COMP_PREP))
    else $error("accepted transaction did not start processing");

  // a new result only comes from the finish step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FINISH))
    else $error("result raised outside the finish step");

  // unchanged flag means the stored velocity kept its value
  a_change_flag: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && !changed_r) |-> $stable(stored_vel_r))
    else $error("velocity changed without the change flag");

  // hundreds scaling runs in imperial mode only
  a_imperial_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IMP_MUL) |-> cfg_imperial_r)
    else $error("imperial scaling in metric mode");

endmodule

### sv/avfs_div.sv
// avfs_div: iterative unsigned restoring divider, two quotient bits per cycle
// depends on avfs_pkg; shared by the compensation and the segment division

module avfs_div import avfs_pkg::*; #(
  parameter int NUM_W = 40,
  parameter int DIV_W = DEN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int ITER  = NUM_W / 2;
  localparam int CNT_W = $clog2(ITER + 1);

  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DIV_W:0]   r1;
  logic [DIV_W:0]   r2;
  logic [DIV_W:0]   r1_sub;
  logic [DIV_W:0]   r2_sub;
  logic             ge1;
  logic             ge2;
  logic [DIV_W-1:0] r1_nxt;
  logic [DIV_W-1:0] rem_nxt;

  // two chained compare-and-subtract steps
  always_comb begin
    r1      = {rem_r, quo_r[NUM_W-1]};
    r1_sub  = r1 - {1'b0, den_r};
    ge1     = (r1 >= {1'b0, den_r});
    r1_nxt  = ge1 ? r1_sub[DIV_W-1:0] : r1[DIV_W-1:0];
    r2      = {r1_nxt, quo_r[NUM_W-2]};
    r2_sub  = r2 - {1'b0, den_r};
    ge2     = (r2 >= {1'b0, den_r});
    rem_nxt = ge2 ? r2_sub[DIV_W-1:0] : r2[DIV_W-1:0];
  end

  // control: iteration count and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(ITER);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - CNT_W'(1);
      done_r <= (cnt_r == CNT_W'(1));
      busy_r <= (cnt_r != CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-3:0], ge1, ge2};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

### test/tb_airflow_velocity_from_sensor_adc.sv
`timescale 1ns / 100ps
// tb_airflow_velocity_from_sensor_adc: self-checking regression of the airflow velocity block
// predicts each result locally over directed and randomized calibrations, with random idling
// depends on avfs_pkg, the avfs_if channel interfaces and the airflow_velocity_from_sensor_adc rtl

module tb_airflow_velocity_from_sensor_adc;
  import avfs_pkg::*;

  localparam int     FRAC_BITS     = 8;
  localparam longint FX_ONE        = longint'(1) << FRAC_BITS;
  localparam longint FX_HALF       = longint'(1) << (FRAC_BITS - 1);
  localparam longint FX_SAT        = longint'(1) << 44;
  localparam longint IMP_WINDOW    = ((longint'(19685) << FRAC_BITS) + 50) / 100;
  localparam longint IMP_OFFSET    = ((longint'(98425) << FRAC_BITS) + 500) / 1000;
  localparam int     SETTLE_CYCLES = 64;
  localparam int     CYCLE_LIMIT   = 800000;
  localparam int     RANDOM_PHASES = 25;
  localparam int     PHASE_SAMPLES = 50;
  localparam int     REPORT_CAP    = 50;

  typedef struct {
    logic [ADC_W-1:0]         adc_sample;
    logic signed [TEMP_W-1:0] temperature;
  } sample_t;

  typedef struct {
    logic [VEL_OUT_W-1:0] velocity;
    logic [CADC_W-1:0]    compensated_adc;
    logic                 velocity_changed;
  } reading_t;

  typedef struct {
    longint adc_zero, adc_low, adc_nominal;
    longint vel_zero, vel_low, vel_nominal;
    longint sensor_const;
    bit     imperial;
  } calibration_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  avfs_in_if  in_ch();
  avfs_out_if out_ch();

  airflow_velocity_from_sensor_adc #(
    .ADC_BITS      (12),
    .FRACTION_BITS (FRAC_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // local copy of the calibration registers and the stored velocity
  calibration_t         cal;
  logic [VEL_OUT_W-1:0] held_velocity = '0;

  sample_t     sample_queue[$];
  reading_t    reading_queue[$];
  sample_t     driven_sample;
  int unsigned samples_queued;
  int unsigned samples_accepted;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned input_gap;
  int unsigned output_stall;
  bit          steady;
  int          temp_corners[5] = '{-4000, 2500, 5000, 5001, 12500};

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one calibration segment in fixed point, saturating on equal adc points
  function automatic longint interpolate(longint x, longint x0, longint x1,
                                         longint y0, longint y1);
    longint dy, dq, dx, num;
    dy  = y1 - y0;
    dq  = (dy == 0) ? 1 : dy * FX_ONE;
    dx  = x1 - x0;
    num = (x - x0) * dq;
    if (dx == 0) begin
      if (num == 0) return y0 * FX_ONE;
      return (num > 0) ? FX_SAT : -FX_SAT;
    end
    return num / dx + y0 * FX_ONE;
  endfunction

  // expected reading for one sample; updates the stored velocity
  function automatic reading_t compute_reading(sample_t s);
    longint               adc, t, k, c, vel, diff, vlow, vnom, level;
    logic [VEL_OUT_W-1:0] new_velocity;
    reading_t             r;
    adc = longint'(s.adc_sample);
    t   = longint'(s.temperature);

    // temperature compensation, skipped when disabled or above 50 C
    c = adc;
    if (cal.sensor_const != 0 && t <= 5000) begin
      k = cal.sensor_const * 100;
      c = adc * (t - 2500 + k) / k;
      if (c < 0) c = adc;
    end
    if (c > 65535) c = 65535;

    // zero region, then the two calibration segments
    if (c < cal.adc_zero) vel = 0;
    else if (c < cal.adc_low)
      vel = interpolate(c, cal.adc_zero, cal.adc_low, cal.vel_zero, cal.vel_low);
    else
      vel = interpolate(c, cal.adc_low, cal.adc_nominal, cal.vel_low, cal.vel_nominal);

    // pull down near the low alarm point: half a unit in metric, the imperial offset otherwise
    vlow = cal.vel_low * FX_ONE;
    vnom = cal.vel_nominal * FX_ONE;
    diff = vel - vlow;
    if (diff < 0) diff = -diff;
    if (cal.imperial) begin
      if (diff <= IMP_WINDOW) vel -= IMP_OFFSET;
    end else if (diff <= FX_ONE) begin
      vel -= FX_HALF;
    end

    // truncate above nominal, round otherwise; imperial in whole hundreds
    if (vel <= 0) level = 0;
    else if (cal.imperial) begin
      if (vel > vnom) level = (vel / (100 * FX_ONE)) * 100;
      else level = ((vel + 50 * FX_ONE) / (100 * FX_ONE)) * 100;
    end else if (vel > vnom) begin
      level = vel / FX_ONE;
    end else begin
      level = (vel + FX_HALF) / FX_ONE;
    end
    if (level > 65535) level = 65535;

    new_velocity       = VEL_OUT_W'(level);
    r.velocity_changed = (new_velocity != held_velocity);
    held_velocity      = new_velocity;
    r.velocity         = new_velocity;
    r.compensated_adc  = CADC_W'(c);
    return r;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // register value biased toward its extremes
  function automatic int unsigned pick_extreme(int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 30) return hi;
    return $urandom_range(0, hi);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
  endtask

  task automatic write_reg(avfs_reg_t idx, int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    case (idx)
      REG_ADC_ZERO:     cal.adc_zero     = value & 'hFFF;
      REG_ADC_LOW:      cal.adc_low      = value & 'hFFF;
      REG_ADC_NOMINAL:  cal.adc_nominal  = value & 'hFFF;
      REG_VEL_ZERO:     cal.vel_zero     = value & 'hFFFF;
      REG_VEL_LOW:      cal.vel_low      = value & 'hFFFF;
      REG_VEL_NOMINAL:  cal.vel_nominal  = value & 'hFFFF;
      REG_SENSOR_CONST: cal.sensor_const = value & 'h3FF;
      REG_IMPERIAL:     cal.imperial     = value[0];
      default: ;
    endcase
  endtask

  task automatic program_calibration(int unsigned az, int unsigned al, int unsigned an,
                                     int unsigned vz, int unsigned vl, int unsigned vn,
                                     int unsigned k, int unsigned imp);
    write_reg(REG_ADC_ZERO, az);
    write_reg(REG_ADC_LOW, al);
    write_reg(REG_ADC_NOMINAL, an);
    write_reg(REG_VEL_ZERO, vz);
    write_reg(REG_VEL_LOW, vl);
    write_reg(REG_VEL_NOMINAL, vn);
    write_reg(REG_SENSOR_CONST, k);
    write_reg(REG_IMPERIAL, imp);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_sample(int unsigned adc, int temp);
    sample_t s;
    s.adc_sample  = ADC_W'(adc);
    s.temperature = TEMP_W'(temp);
    sample_queue.push_back(s);
    samples_queued++;
  endtask

  // every queued sample taken and every reading returned
  task automatic wait_drained();
    while (samples_accepted != samples_queued || reading_queue.size() != 0) @(posedge clk);
  endtask

  // sample driver: predicts on each accepted transaction, then offers the next sample
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.adc_sample  <= '0;
      in_ch.temperature <= '0;
      input_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        reading_queue.push_back(compute_reading(driven_sample));
        samples_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (input_gap > 0) begin
          input_gap--;
          in_ch.valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          driven_sample = sample_queue.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.adc_sample  <= driven_sample.adc_sample;
          in_ch.temperature <= driven_sample.temperature;
          input_gap = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each transaction against the oldest expected reading
  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      output_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (reading_queue.size() == 0) begin
          report_mismatch("unexpected reading, velocity", out_ch.velocity, 0);
        end else begin
          want = reading_queue.pop_front();
          if (out_ch.velocity !== want.velocity)
            report_mismatch("velocity", out_ch.velocity, want.velocity);
          if (out_ch.compensated_adc !== want.compensated_adc)
            report_mismatch("compensated_adc", out_ch.compensated_adc, want.compensated_adc);
          if (out_ch.velocity_changed !== want.velocity_changed)
            report_mismatch("velocity_changed", out_ch.velocity_changed,
                            want.velocity_changed);
        end
      end
      // stalls start at random, whether or not a reading is waiting
      if (output_stall > 0) begin
        output_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) output_stall = pick_gap();
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("airflow_velocity_from_sensor_adc regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned pts[$];
    int unsigned vels[$];
    int unsigned span, k, imp, sel;
    int          adc, temp;

    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_ADC_ZERO;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset calibration: all points equal at zero
    queue_sample(0, -4000);
    queue_sample(1, 12500);
    queue_sample(4095, 0);
    wait_drained();

    // every calibration point at its maximum, compensation constant 1000, imperial
    program_calibration(4095, 4095, 4095, 65535, 65535, 65535, 1000, 1);
    queue_sample(4095, -4000);
    queue_sample(4094, 5000);
    queue_sample(4095, 5001);
    wait_drained();

    // metric, flat first segment, no compensation: zero, both segments, extrapolation
    program_calibration(400, 1200, 3000, 50, 50, 200, 0, 0);
    queue_sample(0, -4000);
    queue_sample(399, 0);
    queue_sample(400, 12500);
    queue_sample(800, 2500);
    queue_sample(1199, 5000);
    queue_sample(1200, 5001);
    queue_sample(1201, -1);
    queue_sample(2100, 100);
    queue_sample(3000, 2500);
    queue_sample(3001, 2500);
    queue_sample(4095, 12500);
    wait_drained();

    // imperial, falling velocity into equal low and nominal points, K = 1
    program_calibration(100, 2000, 2000, 500, 9000, 3000, 1, 1);
    queue_sample(4095, 5000);
    queue_sample(100, -4000);
    queue_sample(1000, 5001);
    queue_sample(2000, 2500);
    queue_sample(2001, 2500);
    queue_sample(50, 2500);
    queue_sample(1500, 2500);
    queue_sample(0, 2600);
    wait_drained();

    // random calibrations, samples clustered around the calibration points
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      steady = ($urandom_range(0, 3) == 0);
      pts    = {pick_extreme(4095), pick_extreme(4095), pick_extreme(4095)};
      if ($urandom_range(0, 3) != 0) pts.sort();
      imp  = $urandom_range(0, 1);
      span = imp ? $urandom_range(2000, 65535)
                 : (($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(50, 4000));
      vels = {pick_extreme(span), pick_extreme(span), pick_extreme(span)};
      if ($urandom_range(0, 9) < 6) vels.sort();
      case ($urandom_range(0, 4))
        0:       k = 0;
        1:       k = 1000;
        2:       k = 1;
        default: k = $urandom_range(1, 1000);
      endcase
      program_calibration(pts[0], pts[1], pts[2], vels[0], vels[1], vels[2], k, imp);

      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          adc = int'(pts[$urandom_range(0, 2)]) + int'($urandom_range(0, 16)) - 8;
          if (adc < 0) adc = 0;
          if (adc > 4095) adc = 4095;
        end else if (sel < 55) begin
          adc = $urandom_range(0, 1) ? 4095 : 0;
        end else begin
          adc = $urandom_range(0, 4095);
        end
        if ($urandom_range(0, 99) < 30) temp = temp_corners[$urandom_range(0, 4)];
        else temp = int'($urandom_range(0, 16500)) - 4000;
        queue_sample(adc, temp);
      end
      wait_drained();
    end

    // let any stray reading show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (reading_queue.size() != 0)
      report_mismatch("readings never returned", 0, reading_queue.size());
    if (mismatch_count == 0) begin
      $display("airflow_velocity_from_sensor_adc regression: pass");
    end else begin
      $display("airflow_velocity_from_sensor_adc regression: fail");
    end
    $finish;
  end

endmodule
